FILE: src/ckms_pkg.sv
// Shared types and constants for the capacitive key matrix scanner.
// No dependencies.
package ckms_pkg;

    localparam int ROW_SEL_W  = 3;
    localparam int COL_SEL_W  = 4;
    localparam int ROW_BITS_W = 16;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER      = 2'd2;

    localparam logic [CFG_W-1:0] SELECT_DELAY_RST = 8'd1;
    localparam logic [CFG_W-1:0] ENABLE_HOLD_RST  = 8'd2;
    localparam logic [CFG_W-1:0] RECOVER_RST      = 8'd25;

    typedef enum logic [1:0] {
        PH_SELECT  = 2'd0,
        PH_ENABLE  = 2'd1,
        PH_RECOVER = 2'd2
    } t_phase;

    typedef struct packed {
        logic en;
        logic hys_on;
        logic sample;
        logic last;
    } t_seq_ctl;

endpackage

FILE: src/ckms_seq.sv
// Key timing sequencer: phase, tick counter and row/column address.
// Depends on ckms_pkg.
module ckms_seq
    import ckms_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 16,
    parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
    parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [CFG_W-1:0] i_select_delay,
    input  logic [CFG_W-1:0] i_enable_hold,
    input  logic [CFG_W-1:0] i_recover,
    output logic [RW-1:0]    o_row,
    output logic [CW-1:0]    o_col,
    output t_seq_ctl         o_ctl
);

    t_phase           r_phase, n_phase;
    logic [CFG_W-1:0] r_wait, n_wait;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [CFG_W-1:0] wait_inc;
    logic             last_row, last_col, advance;

    assign wait_inc = r_wait + 1'b1;
    assign last_row = (r_row == RW'(ROWS - 1));
    assign last_col = (r_col == CW'(COLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SELECT;
            r_wait  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_wait       = r_wait;
        advance      = 1'b0;
        o_ctl.en     = 1'b0;
        o_ctl.hys_on = 1'b0;
        o_ctl.sample = 1'b0;
        o_ctl.last   = last_row && last_col;
        unique case (r_phase)
            PH_ENABLE: begin
                o_ctl.en     = 1'b1;
                o_ctl.hys_on = 1'b1;
                if (wait_inc >= i_enable_hold) begin
                    o_ctl.sample = 1'b1;
                    if (i_recover == '0) begin
                        advance = 1'b1;
                    end else begin
                        n_phase = PH_RECOVER;
                        n_wait  = '0;
                    end
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_RECOVER: begin
                if (wait_inc >= i_recover) begin
                    advance = 1'b1;
                end else begin
                    n_wait = wait_inc;
                end
            end
            default: begin
                o_ctl.hys_on = 1'b1;
                if (r_wait >= i_select_delay) begin
                    n_phase = PH_ENABLE;
                    n_wait  = '0;
                end else begin
                    n_phase = PH_SELECT;
                    n_wait  = wait_inc;
                end
            end
        endcase

        n_row = r_row;
        n_col = r_col;
        if (advance) begin
            n_phase = PH_SELECT;
            n_wait  = '0;
            if (last_row) begin
                n_row = '0;
                n_col = last_col ? '0 : r_col + 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;

endmodule

FILE: src/capacitive_key_matrix_scanner.sv
// Top level of the capacitive key matrix scanner: config, key bitmap, output register.
// Depends on ckms_pkg and ckms_seq.
//
// Usage: every request on the input channel is one timing tick (nominally
// 1 us) carrying the sense pin level. Each accepted request yields exactly one
// result request on the output channel with the pin drives for that tick
// (row/col select, enable, hysteresis) and, on sample ticks, the updated row
// bitmap plus end-of-scan status.
// Latency: the result is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle unless the output stalls; the sequencer and bitmap
// update sit in one stage between the accept edge and the result register.
// Stall: while the result register holds an untaken result, a new tick is
// accepted only in the cycle the result is taken, so nothing is lost.
// Reset: bitmap cleared, address at row 0 column 0, select phase, timing
// registers to 1/2/25, no result pending.
// Config writes: index 0 select delay, 1 enable hold, 2 recovery; other
// indexes are ignored. Write only while the block is idle.
module capacitive_key_matrix_scanner
    import ckms_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_sense_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ROW_SEL_W-1:0]  o_row_select,
    output logic [COL_SEL_W-1:0]  o_col_select,
    output logic                  o_enable_drive,
    output logic                  o_hysteresis_drive,
    output logic                  o_sample_taken,
    output logic [ROW_BITS_W-1:0] o_row_bits,
    output logic                  o_scan_done,
    output logic                  o_scan_changed
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [CFG_W-1:0] r_select_delay, r_enable_hold, r_recover;
    logic [COLS-1:0]  r_bitmap [ROWS];
    logic             r_changed;
    logic             r_out_valid;

    logic [ROW_SEL_W-1:0]  r_row_select;
    logic [COL_SEL_W-1:0]  r_col_select;
    logic                  r_enable, r_hys, r_sample, r_done, r_chg;
    logic [ROW_BITS_W-1:0] r_row_bits;

    logic            step;
    logic [RW-1:0]   row;
    logic [CW-1:0]   col;
    t_seq_ctl        ctl;
    logic [COLS-1:0] mask, old_bits, n_bits;
    logic            stored, bit_diff, done;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_delay <= SELECT_DELAY_RST;
            r_enable_hold  <= ENABLE_HOLD_RST;
            r_recover      <= RECOVER_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_SELECT_DELAY: r_select_delay <= i_cfg_data;
                CFG_ENABLE_HOLD:  r_enable_hold  <= i_cfg_data;
                CFG_RECOVER:      r_recover      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ckms_seq #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW),
        .CW   (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_select_delay (r_select_delay),
        .i_enable_hold  (r_enable_hold),
        .i_recover      (r_recover),
        .o_row          (row),
        .o_col          (col),
        .o_ctl          (ctl)
    );

    assign mask     = COLS'(1) << col;
    assign old_bits = r_bitmap[row];
    assign stored   = old_bits[col];
    assign n_bits   = i_sense_level ? (old_bits & ~mask) : (old_bits | mask);
    assign bit_diff = (n_bits != old_bits);
    assign done     = ctl.sample && ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_bitmap[i] <= '0;
            end
            r_changed <= 1'b0;
        end else if (step && ctl.sample) begin
            r_bitmap[row] <= n_bits;
            if (done) begin
                r_changed <= 1'b0;
            end else if (bit_diff) begin
                r_changed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_row_select <= ROW_SEL_W'(row);
            r_col_select <= COL_SEL_W'(col);
            r_enable     <= ctl.en;
            r_hys        <= ctl.hys_on && stored;
            r_sample     <= ctl.sample;
            r_row_bits   <= ctl.sample ? ROW_BITS_W'(n_bits) : '0;
            r_done       <= done;
            r_chg        <= done && (r_changed || bit_diff);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_row_select       = r_row_select;
    assign o_col_select       = r_col_select;
    assign o_enable_drive     = r_enable;
    assign o_hysteresis_drive = r_hys;
    assign o_sample_taken     = r_sample;
    assign o_row_bits         = r_row_bits;
    assign o_scan_done        = r_done;
    assign o_scan_changed     = r_chg;

endmodule
